// ----- design/wtns_pkg.sv -----
`default_nettype none
package wtns_pkg;
  localparam int MaxPoints = 64;
  localparam int MaxPaths = 128;
  localparam int PtIdxW = $clog2(MaxPoints);
  localparam int PaIdxW = $clog2(MaxPaths);
  localparam int PtCntW = PtIdxW + 1;
  localparam int PaCntW = PaIdxW + 1;

  typedef enum logic [2:0] {
    CMD_NEW_POINT = 3'd0,
    CMD_NEAREST   = 3'd1,
    CMD_DEL_NEAR  = 3'd2,
    CMD_NEW_PATH  = 3'd3,
    CMD_GET_PATH  = 3'd4,
    CMD_DEL_PATH  = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_NF   = 2'd1,
    ST_FULL = 2'd2,
    ST_DUP  = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [15:0]        search_radius;
    logic [15:0]        first_id;
    logic [15:0]        second_id;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [15:0]        found_id;
    logic signed [15:0] found_x;
    logic signed [15:0] found_y;
    logic [16:0]        path_length;
  } out_t;

  // point entry: id, x, y, age
  localparam int PtW = 64;
  // path entry: ends (32), length (17)
  localparam int PaW = 49;

  typedef enum logic [3:0] {
    S_IDLE, S_PSCAN, S_PEVAL, S_PWRITE, S_ASCAN, S_AFIX,
    S_KSCAN, S_KFIX, S_SQRT, S_PAWRITE, S_DONE
  } state_e;
endpackage
`default_nettype wire

// ----- design/wtns_ram.sv -----
`default_nettype none
module wtns_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

// ----- design/wtns_isqrt.sv -----
`default_nettype none
module wtns_isqrt (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start_i,
  input  wire logic [33:0] n_i,
  output logic             done_o,
  output logic [16:0]      root_o
);
  // one result bit per cycle, restoring method
  logic [33:0] rem_q, rem_d;
  logic [33:0] res_q, res_d;
  logic [33:0] bit_q, bit_d;
  logic        run_q, run_d;
  always_comb begin
    rem_d = rem_q; res_d = res_q; bit_d = bit_q; run_d = run_q;
    done_o = 1'b0;
    if (start_i) begin
      rem_d = n_i; res_d = '0; bit_d = 34'h1 << 32; run_d = 1'b1;
    end else if (run_q) begin
      if (bit_q == '0) begin
        run_d = 1'b0;
        done_o = 1'b1;
      end else begin
        if (rem_q >= res_q + bit_q) begin
          rem_d = rem_q - (res_q + bit_q);
          res_d = (res_q >> 1) + bit_q;
        end else begin
          res_d = res_q >> 1;
        end
        bit_d = bit_q >> 2;
      end
    end
  end
  assign root_o = res_q[16:0];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) run_q <= 1'b0;
    else run_q <= run_d;
  end
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d; res_q <= res_d; bit_q <= bit_d;
  end
endmodule
`default_nettype wire

// ----- design/waypoint_table_nearest_search_core.sv -----
`default_nettype none
// Sequence: nearest and new point scan points; delete nearest scans points, paths, then
//   points again; new path scans points, then paths if both ids are found, then takes a
//   square root unless duplicate or path table full; get/delete path scan paths only.
// Throughput: one transaction at a time; busy drops in the done_o cycle, so the next
//   transaction can be accepted there. The receiver cannot stall.
// Reset: valid bits, id counter and point count clear asynchronously; memories do not.
module waypoint_table_nearest_search_core (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  input  wire wtns_pkg::in_t    data_i,
  output logic                  busy,
  output logic                  done_o,
  output wtns_pkg::out_t        result_o
);
  localparam int PI = wtns_pkg::PtIdxW;
  localparam int AI = wtns_pkg::PaIdxW;

  wtns_pkg::state_e st_q, st_d;
  wtns_pkg::in_t    cmd_q;
  logic [wtns_pkg::MaxPoints-1:0] pv_q, pv_d;
  logic [wtns_pkg::MaxPaths-1:0]  av_q, av_d;
  logic [15:0]      idc_q, idc_d;
  logic [wtns_pkg::PtCntW-1:0] pcnt_q, pcnt_d;

  // scan counters: address issued and address of returning data
  logic [wtns_pkg::PtCntW-1:0] pa_q, pa_d;
  logic [wtns_pkg::PaCntW-1:0] aa_q, aa_d;
  logic pr_q, pr_d;                   // read data valid
  logic [PI-1:0] prd_q, prd_d;        // index of returning data
  logic [AI-1:0] ard_q, ard_d;

  // point and path memories
  logic ptwe; logic [PI-1:0] ptwa, ptra; logic [63:0] ptwd, ptrd;
  wtns_ram #(.Width(wtns_pkg::PtW), .Depth(wtns_pkg::MaxPoints)) u_pt (
    .clk_i, .we_i(ptwe), .waddr_i(ptwa), .wdata_i(ptwd),
    .raddr_i(ptra), .rdata_o(ptrd));
  logic pawe; logic [AI-1:0] pawa, para; logic [48:0] pawd, pard;
  wtns_ram #(.Width(wtns_pkg::PaW), .Depth(wtns_pkg::MaxPaths)) u_pa (
    .clk_i, .we_i(pawe), .waddr_i(pawa), .wdata_i(pawd),
    .raddr_i(para), .rdata_o(pard));

  wire [15:0] e_id  = ptrd[63:48];
  wire signed [15:0] e_x = ptrd[47:32];
  wire signed [15:0] e_y = ptrd[31:16];
  wire [15:0] e_age = ptrd[15:0];

  // best-match tracking
  logic        bf_q, bf_d;            // nearest/first id found
  logic [PI-1:0] bi_q, bi_d;
  logic [63:0] be_q, be_d;
  logic [32:0] bd_q, bd_d;
  logic        sf_q, sf_d;            // second id found
  logic [63:0] se_q, se_d;
  logic        ff_q, ff_d;            // free slot found
  logic [PI-1:0] fi_q, fi_d;
  logic        kf_q, kf_d;            // path match found
  logic [16:0] kl_q, kl_d;
  logic        af_q, af_d;            // free path slot
  logic [AI-1:0] ai_q, ai_d;
  logic        anyd_q, anyd_d;        // any path deleted

  // squared distance of the returning entry
  logic signed [16:0] dx, dy;
  logic [32:0] qdist;
  assign dx = $signed({cmd_q.pos_x[15], cmd_q.pos_x}) - $signed({e_x[15], e_x});
  assign dy = $signed({cmd_q.pos_y[15], cmd_q.pos_y}) - $signed({e_y[15], e_y});
  assign qdist = {1'b0, 32'(dx * dx)} + {1'b0, 32'(dy * dy)};

  // sqrt of endpoint distance
  logic sq_start, sq_done; logic [16:0] sq_root;
  logic signed [16:0] px, py;
  logic [33:0] pdist;
  assign px = $signed({be_q[47], be_q[47:32]}) - $signed({se_q[47], se_q[47:32]});
  assign py = $signed({be_q[31], be_q[31:16]}) - $signed({se_q[31], se_q[31:16]});
  assign pdist = {2'b0, 32'(px * px)} + {2'b0, 32'(py * py)};
  logic [33:0] pdist_q;
  wtns_isqrt u_sqrt (.clk_i, .rst_ni, .start_i(sq_start), .n_i(pdist_q),
    .done_o(sq_done), .root_o(sq_root));

  wtns_pkg::out_t res_q, res_d;
  logic done_q, done_d;

  wire [15:0] pe_a = pard[15:0];
  wire [15:0] pe_b = pard[31:16];
  wire pmatch = (pe_a == cmd_q.first_id && pe_b == cmd_q.second_id) ||
                (pe_a == cmd_q.second_id && pe_b == cmd_q.first_id);
  wire [32:0] rad2 = {1'b0, 32'(cmd_q.search_radius * cmd_q.search_radius)};

  // next state
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      wtns_pkg::S_IDLE: begin
        if (start) begin
          if (data_i.command == wtns_pkg::CMD_NEW_POINT ||
              data_i.command == wtns_pkg::CMD_NEAREST ||
              data_i.command == wtns_pkg::CMD_DEL_NEAR ||
              data_i.command == wtns_pkg::CMD_NEW_PATH) st_d = wtns_pkg::S_PSCAN;
          else if (data_i.command == wtns_pkg::CMD_GET_PATH ||
                   data_i.command == wtns_pkg::CMD_DEL_PATH) st_d = wtns_pkg::S_KSCAN;
          else st_d = wtns_pkg::S_DONE;
        end
      end
      wtns_pkg::S_PSCAN:
        if (pa_q == wtns_pkg::PtCntW'(wtns_pkg::MaxPoints) && !pr_q) st_d = wtns_pkg::S_PEVAL;
      wtns_pkg::S_PEVAL: begin
        unique case (cmd_q.command)
          wtns_pkg::CMD_NEW_POINT: st_d = ff_q ? wtns_pkg::S_PWRITE : wtns_pkg::S_DONE;
          wtns_pkg::CMD_DEL_NEAR: st_d = (bf_q && (cmd_q.search_radius == '0 || bd_q <= rad2))
                                           ? wtns_pkg::S_KSCAN : wtns_pkg::S_DONE;
          wtns_pkg::CMD_NEW_PATH: st_d = (bf_q && sf_q) ? wtns_pkg::S_KSCAN : wtns_pkg::S_DONE;
          default: st_d = wtns_pkg::S_DONE;
        endcase
      end
      wtns_pkg::S_PWRITE: st_d = wtns_pkg::S_DONE;
      wtns_pkg::S_KSCAN:
        if (aa_q == wtns_pkg::PaCntW'(wtns_pkg::MaxPaths) && !pr_q) st_d = wtns_pkg::S_KFIX;
      wtns_pkg::S_KFIX: begin
        if (cmd_q.command == wtns_pkg::CMD_DEL_NEAR) st_d = wtns_pkg::S_ASCAN;
        else if (cmd_q.command == wtns_pkg::CMD_NEW_PATH && !kf_q && af_q)
          st_d = wtns_pkg::S_SQRT;
        else st_d = wtns_pkg::S_DONE;
      end
      wtns_pkg::S_ASCAN:
        if (pa_q == wtns_pkg::PtCntW'(wtns_pkg::MaxPoints) && !pr_q) st_d = wtns_pkg::S_DONE;
      wtns_pkg::S_SQRT: if (sq_done) st_d = wtns_pkg::S_PAWRITE;
      wtns_pkg::S_PAWRITE: st_d = wtns_pkg::S_DONE;
      wtns_pkg::S_AFIX: st_d = wtns_pkg::S_DONE;
      wtns_pkg::S_DONE: st_d = wtns_pkg::S_IDLE;
      default: st_d = wtns_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    pv_d = pv_q; av_d = av_q; idc_d = idc_q; pcnt_d = pcnt_q;
    pa_d = pa_q; aa_d = aa_q; pr_d = 1'b0; prd_d = prd_q; ard_d = ard_q;
    bf_d = bf_q; bi_d = bi_q; be_d = be_q; bd_d = bd_q; sf_d = sf_q; se_d = se_q;
    ff_d = ff_q; fi_d = fi_q; kf_d = kf_q; kl_d = kl_q;
    af_d = af_q; ai_d = ai_q; anyd_d = anyd_q;
    res_d = res_q; done_d = 1'b0;
    ptwe = 1'b0; ptwa = fi_q; ptwd = '0; ptra = pa_q[PI-1:0];
    pawe = 1'b0; pawa = ai_q; pawd = '0; para = aa_q[AI-1:0];
    sq_start = 1'b0;
    unique case (st_q)
      wtns_pkg::S_IDLE: begin
        pa_d = '0; aa_d = '0;
        bf_d = 1'b0; sf_d = 1'b0; ff_d = 1'b0; kf_d = 1'b0; af_d = 1'b0; anyd_d = 1'b0;
        res_d = '{status: wtns_pkg::ST_NF, default: '0};
      end
      wtns_pkg::S_PSCAN, wtns_pkg::S_ASCAN: begin
        if (pa_q != wtns_pkg::PtCntW'(wtns_pkg::MaxPoints)) begin
          pr_d = 1'b1; prd_d = pa_q[PI-1:0]; pa_d = pa_q + 1'b1;
        end
        if (pr_q && st_q == wtns_pkg::S_PSCAN) begin
          if (!pv_q[prd_q]) begin
            if (!ff_q) begin ff_d = 1'b1; fi_d = prd_q; end
          end else if (cmd_q.command == wtns_pkg::CMD_NEW_PATH) begin
            if (e_id == cmd_q.first_id && (!bf_q || e_age < be_q[15:0])) begin
              bf_d = 1'b1; be_d = ptrd;
            end
            if (e_id == cmd_q.second_id && (!sf_q || e_age < se_q[15:0])) begin
              sf_d = 1'b1; se_d = ptrd;
            end
          end else if (!bf_q || qdist < bd_q || (qdist == bd_q && e_age < be_q[15:0])) begin
            bf_d = 1'b1; bi_d = prd_q; be_d = ptrd; bd_d = qdist;
          end
        end
        if (pr_q && st_q == wtns_pkg::S_ASCAN && pv_q[prd_q] &&
            e_age > be_q[15:0]) begin
          ptwe = 1'b1; ptwa = prd_q; ptwd = {ptrd[63:16], e_age - 16'd1};
        end
      end
      wtns_pkg::S_PEVAL: begin
        if (cmd_q.command == wtns_pkg::CMD_NEW_POINT) begin
          if (!ff_q) res_d.status = wtns_pkg::ST_FULL;
        end else if ((cmd_q.command == wtns_pkg::CMD_NEAREST ||
                      cmd_q.command == wtns_pkg::CMD_DEL_NEAR) && bf_q &&
                     (cmd_q.search_radius == '0 || bd_q <= rad2)) begin
          res_d.status = wtns_pkg::ST_OK;
          res_d.found_id = be_q[63:48];
          res_d.found_x = be_q[47:32];
          res_d.found_y = be_q[31:16];
        end
      end
      wtns_pkg::S_PWRITE: begin
        idc_d = idc_q + 16'd1;
        ptwe = 1'b1; ptwa = fi_q;
        ptwd = {idc_d, cmd_q.pos_x, cmd_q.pos_y, 16'(pcnt_q)};
        pv_d[fi_q] = 1'b1; pcnt_d = pcnt_q + 1'b1;
        res_d.status = wtns_pkg::ST_OK;
        res_d.found_id = idc_d;
        res_d.found_x = cmd_q.pos_x; res_d.found_y = cmd_q.pos_y;
      end
      wtns_pkg::S_KSCAN: begin
        if (aa_q != wtns_pkg::PaCntW'(wtns_pkg::MaxPaths)) begin
          pr_d = 1'b1; ard_d = aa_q[AI-1:0]; aa_d = aa_q + 1'b1;
        end
        if (pr_q) begin
          if (!av_q[ard_q]) begin
            if (!af_q) begin af_d = 1'b1; ai_d = ard_q; end
          end else if (cmd_q.command == wtns_pkg::CMD_DEL_NEAR) begin
            if (pe_a == be_q[63:48] || pe_b == be_q[63:48]) av_d[ard_q] = 1'b0;
          end else if (cmd_q.command == wtns_pkg::CMD_DEL_PATH) begin
            if (pmatch) begin av_d[ard_q] = 1'b0; anyd_d = 1'b1; end
          end else if (pmatch && !kf_q) begin
            kf_d = 1'b1; kl_d = pard[48:32];
          end
        end
      end
      wtns_pkg::S_KFIX: begin
        pa_d = '0;
        unique case (cmd_q.command)
          wtns_pkg::CMD_DEL_NEAR: begin
            pv_d[bi_q] = 1'b0; pcnt_d = pcnt_q - 1'b1;
          end
          wtns_pkg::CMD_DEL_PATH: if (anyd_q) res_d.status = wtns_pkg::ST_OK;
          wtns_pkg::CMD_GET_PATH: if (kf_q) begin
            res_d.status = wtns_pkg::ST_OK; res_d.path_length = kl_q;
          end
          wtns_pkg::CMD_NEW_PATH: begin
            if (kf_q) begin
              res_d.status = wtns_pkg::ST_DUP; res_d.path_length = kl_q;
            end else if (!af_q) res_d.status = wtns_pkg::ST_FULL;
            else sq_start = 1'b1;
          end
          default: ;
        endcase
      end
      wtns_pkg::S_SQRT: begin
        if (sq_done) begin
          res_d.status = wtns_pkg::ST_OK; res_d.path_length = sq_root;
        end
      end
      wtns_pkg::S_PAWRITE: begin
        pawe = 1'b1; pawa = ai_q;
        pawd = {res_q.path_length, cmd_q.second_id, cmd_q.first_id};
        av_d[ai_q] = 1'b1;
      end
      wtns_pkg::S_DONE: done_d = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (st_q == wtns_pkg::S_PEVAL) pdist_q <= pdist;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= wtns_pkg::S_IDLE; pv_q <= '0; av_q <= '0; idc_q <= '0; pcnt_q <= '0;
      pr_q <= 1'b0; done_q <= 1'b0;
    end else begin
      st_q <= st_d; pv_q <= pv_d; av_q <= av_d; idc_q <= idc_d; pcnt_q <= pcnt_d;
      pr_q <= pr_d; done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == wtns_pkg::S_IDLE && start) cmd_q <= data_i;
    pa_q <= pa_d; aa_q <= aa_d; prd_q <= prd_d; ard_q <= ard_d;
    bf_q <= bf_d; bi_q <= bi_d; be_q <= be_d; bd_q <= bd_d; sf_q <= sf_d; se_q <= se_d;
    ff_q <= ff_d; fi_q <= fi_d; kf_q <= kf_d; kl_q <= kl_d;
    af_q <= af_d; ai_q <= ai_d; anyd_q <= anyd_d; res_q <= res_d;
  end

  assign busy = (st_q != wtns_pkg::S_IDLE);
  assign done_o = done_q;
  assign result_o = res_q;
endmodule
`default_nettype wire
